[design/smn_pkg.sv]
package smn_pkg;

	// default build values
	localparam int TAPS_DEF        = 5;
	localparam int SAMPLE_BITS_DEF = 12;

	// percentage scaling, unsigned q7.8 with 25600 for the full window
	localparam int PCT_W    = 15;
	localparam int PCT_FULL = 25600;

	// simulated temperature in hundredths of a degree
	localparam int TEMP_W     = 12;
	localparam int TEMP_Q_W   = 9;
	localparam int TEMP_BASE  = 2500;
	localparam int TEMP_SPAN  = 500;
	localparam int TEMP_TOP   = TEMP_BASE + TEMP_SPAN;

	// configuration register indexes
	localparam int CFG_IDX_W = 1;
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WINDOW_LOW  = 1'b0,
		REG_WINDOW_HIGH = 1'b1
	} smn_reg_t;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MEAN,
		ST_SCALE
	} smn_state_t;

endpackage

[design/smn_if.sv]
// sample channel
interface smn_in_if #(
	parameter int SAMPLE_BITS = smn_pkg::SAMPLE_BITS_DEF
);
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

// result channel
interface smn_out_if #(
	parameter int SAMPLE_BITS = smn_pkg::SAMPLE_BITS_DEF
);
	logic                       valid;
	logic                       ready;
	logic [SAMPLE_BITS-1:0]     smoothed;
	logic [smn_pkg::PCT_W-1:0]  light_percent_q8;
	logic [smn_pkg::TEMP_W-1:0] temp_centi;

	modport source (output valid, output smoothed, output light_percent_q8,
		output temp_centi, input ready);
	modport sink (input valid, input smoothed, input light_percent_q8,
		input temp_centi, output ready);
endinterface

[design/smn_div.sv]
// radix-2 restoring divider, one quotient bit per cycle
// requires num < den * 2**QUO_W
module smn_div #(
	parameter int NUM_W = 16,
	parameter int DEN_W = 8,
	parameter int QUO_W = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             busy,
	output logic [QUO_W-1:0] quo
);
	localparam int CNT_W = $clog2(QUO_W + 1);

	logic [CNT_W-1:0] count_q;
	logic [DEN_W-1:0] rem_q;
	logic [QUO_W-1:0] sh_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W+1:0] diff;
	logic             take;
	logic [DEN_W-1:0] rem_d;

	// trial subtraction of the next partial remainder
	always_comb begin
		trial = {rem_q, sh_q[QUO_W-1]};
		diff  = {1'b0, trial} - {2'b00, den};
		take  = ~diff[DEN_W+1];
		rem_d = take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (start) begin
			count_q <= CNT_W'(QUO_W);
		end else if (busy) begin
			count_q <= count_q - 1'b1;
		end
	end

	// remainder and numerator / quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= DEN_W'(num >> QUO_W);
			sh_q  <= num[QUO_W-1:0];
		end else if (busy) begin
			rem_q <= rem_d;
			sh_q  <= {sh_q[QUO_W-2:0], take};
		end
	end

	assign busy = (count_q != '0);
	assign quo  = sh_q;

endmodule

[design/sensor_moving_average_normalizer.sv]
// channel   dir  handshake      payload
// samples   in   valid/ready    sample
// results   out  valid/ready    smoothed, light_percent_q8, temp_centi
// cfg       in   cfg_we         cfg_index, cfg_data (no read-back)
//
// each item goes from transfer to result in order: the serial divider forms the mean,
// the temperature and percentage dividers then scale the mean together, and the result
// is loaded into the output register.
// a new sample is taken once the previous result sits in the output register.
// arst_n clears the history, running sum, write slot and control state, and sets the window to the full range.
// a stalled result holds the core in the scale state until the output register frees.
module sensor_moving_average_normalizer #(
	parameter int TAPS        = smn_pkg::TAPS_DEF,
	parameter int SAMPLE_BITS = smn_pkg::SAMPLE_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [smn_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [SAMPLE_BITS-1:0]          cfg_data,
	smn_in_if.sink                          samples,
	smn_out_if.source                       results
);
	import smn_pkg::*;

	localparam int B          = SAMPLE_BITS;
	localparam int FULL       = (1 << B) - 1;
	localparam int SLOT_W     = (TAPS > 1) ? $clog2(TAPS) : 1;
	localparam int SUM_W      = $clog2(TAPS * FULL + 1);
	localparam int TAP_W      = $clog2(TAPS + 1);
	localparam int TEMP_NUM_W = B + TEMP_Q_W;
	localparam int PCT_NUM_W  = B + PCT_W;

	smn_state_t state_q, state_d;

	logic [B-1:0]      window_low_q;
	logic [B-1:0]      window_high_q;
	logic [B-1:0]      history_q [TAPS];
	logic [SLOT_W-1:0] slot_q;
	logic [SUM_W-1:0]  sum_q;
	logic [SUM_W-1:0]  sum_d;
	logic              accept;

	logic              mean_start;
	logic              mean_busy;
	logic [B-1:0]      mean_quo;
	logic [B-1:0]      mean_q;

	logic              scale_start;
	logic              temp_busy;
	logic [TEMP_Q_W-1:0] temp_quo;
	logic              pct_busy;
	logic [PCT_W-1:0]  pct_quo;
	logic [TEMP_NUM_W-1:0] temp_num;
	logic [PCT_NUM_W-1:0]  pct_num;
	logic [B-1:0]      clamped;
	logic [B-1:0]      span_c;
	logic [B-1:0]      win_den;
	logic              win_ok;

	logic              load_out;
	logic              out_valid_q;
	logic [B-1:0]      smoothed_q;
	logic [PCT_W-1:0]  pct_q;
	logic [TEMP_W-1:0] temp_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_low_q  <= '0;
			window_high_q <= B'(FULL);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WINDOW_LOW:  window_low_q  <= cfg_data;
				REG_WINDOW_HIGH: window_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// running sum replaces the overwritten entry with the new sample
	assign accept = samples.valid && samples.ready;
	assign sum_d  = sum_q - SUM_W'(history_q[slot_q]) + SUM_W'(samples.sample);

	// circular history, write slot and running sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TAPS; i++) begin
				history_q[i] <= '0;
			end
			slot_q <= '0;
			sum_q  <= '0;
		end else if (accept) begin
			history_q[slot_q] <= samples.sample;
			slot_q <= (slot_q == SLOT_W'(TAPS - 1)) ? '0 : slot_q + 1'b1;
			sum_q  <= sum_d;
		end
	end

	// mean = sum / TAPS
	smn_div #(
		.NUM_W (SUM_W),
		.DEN_W (TAP_W),
		.QUO_W (B)
	) u_mean_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mean_start),
		.num    (sum_d),
		.den    (TAP_W'(TAPS)),
		.busy   (mean_busy),
		.quo    (mean_quo)
	);

	// clamp to the window and form both scaled numerators
	always_comb begin
		win_ok  = window_high_q > window_low_q;
		win_den = window_high_q - window_low_q;
		if (mean_quo < window_low_q) begin
			clamped = window_low_q;
		end else if (mean_quo > window_high_q) begin
			clamped = window_high_q;
		end else begin
			clamped = mean_quo;
		end
		span_c   = clamped - window_low_q;
		temp_num = TEMP_NUM_W'(mean_quo) * TEMP_NUM_W'(TEMP_SPAN);
		pct_num  = PCT_NUM_W'(span_c) * PCT_NUM_W'(PCT_FULL);
	end

	// temperature offset = mean * 500 / FULL
	smn_div #(
		.NUM_W (TEMP_NUM_W),
		.DEN_W (B),
		.QUO_W (TEMP_Q_W)
	) u_temp_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (scale_start),
		.num    (temp_num),
		.den    (B'(FULL)),
		.busy   (temp_busy),
		.quo    (temp_quo)
	);

	// percentage = (clamped - low) * 25600 / (high - low)
	smn_div #(
		.NUM_W (PCT_NUM_W),
		.DEN_W (B),
		.QUO_W (PCT_W)
	) u_pct_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (scale_start),
		.num    (pct_num),
		.den    (win_den),
		.busy   (pct_busy),
		.quo    (pct_quo)
	);

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencer next state and controls
	always_comb begin
		state_d       = state_q;
		samples.ready = 1'b0;
		mean_start    = 1'b0;
		scale_start   = 1'b0;
		load_out      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				samples.ready = 1'b1;
				if (samples.valid) begin
					mean_start = 1'b1;
					state_d    = ST_MEAN;
				end
			end
			ST_MEAN: begin
				if (!mean_busy) begin
					scale_start = 1'b1;
					state_d     = ST_SCALE;
				end
			end
			ST_SCALE: begin
				if (!temp_busy && !pct_busy && (!out_valid_q || results.ready)) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// hold the mean while the scaling dividers run
	always_ff @(posedge clk) begin
		if (scale_start) begin
			mean_q <= mean_quo;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			smoothed_q <= mean_q;
			pct_q      <= win_ok ? pct_quo : '0;
			temp_q     <= TEMP_W'(TEMP_BASE) + TEMP_W'(temp_quo);
		end
	end

	assign results.valid            = out_valid_q;
	assign results.smoothed         = smoothed_q;
	assign results.light_percent_q8 = pct_q;
	assign results.temp_centi       = temp_q;

	// checks
	a_pct_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> pct_q <= PCT_W'(PCT_FULL))
		else $error("percentage beyond full scale");

	a_temp_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (temp_q >= TEMP_W'(TEMP_BASE) && temp_q <= TEMP_W'(TEMP_TOP)))
		else $error("temperature out of range");

	a_sum_range: assert property (@(posedge clk) disable iff (!arst_n)
		sum_q <= SUM_W'(TAPS * FULL))
		else $error("running sum beyond the largest total");

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		slot_q <= SLOT_W'(TAPS - 1))
		else $error("write slot past the last tap");

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		samples.ready |-> (!mean_busy && !temp_busy && !pct_busy))
		else $error("sample taken while a divider still runs");

	a_mean_then_scale: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MEAN && !mean_busy) |=> (temp_busy && pct_busy))
		else $error("scaling dividers did not start after the mean");

endmodule
